>>> design/ept_pkg.sv
// Shared types and constants for the eased pose transition block.
`default_nettype none
package ept_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TRANS = 2'd1,
    OP_TICK  = 2'd2,
    OP_SNAP  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADV,
    S_DIV,
    S_EASE,
    S_D1,
    S_D2,
    S_LMUL,
    S_LADD,
    S_CLOS,
    S_COPY_TGT,
    S_CMP,
    S_DECIDE,
    S_SNAP,
    S_COPY_ST,
    S_EMIT
  } st_e;

  localparam logic [1:0] CURVE_DECEL  = 2'd1;
  localparam logic [1:0] CURVE_SMOOTH = 2'd2;

  localparam logic [10:0] T_FULL      = 11'd1000;
  localparam logic [10:0] T_HALF      = 11'd500;
  localparam logic [10:0] T_CURVED    = 11'd850;
  localparam logic [10:0] T_FILLED    = 11'd150;
  localparam logic signed [15:0] CLOSURE_CURVED = 16'sd1;

  // Reciprocal of 1000 scaled by 2^37, rounded down.
  localparam logic [27:0] RECIP_M     = 28'd137438953;
  localparam int          RECIP_SHIFT = 37;

  typedef struct packed {
    op_e                op;
    logic               load_en;
    logic [3:0]         channel;
    logic signed [15:0] value;
    logic [31:0]        now;
    logic [15:0]        duration;
    logic [1:0]         easing;
  } cmd_t;

endpackage
`default_nettype wire

>>> design/ept_if.sv
// Valid/ready channel interfaces for input items and emitted pose channels.
`default_nettype none
interface ept_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [3:0]         channel;
  logic signed [15:0] value;
  logic [31:0]        now;
  logic [15:0]        duration;
  logic [1:0]         easing;
  modport source(output valid, op, channel, value, now, duration, easing, input ready);
  modport sink(input valid, op, channel, value, now, duration, easing, output ready);
endinterface

interface ept_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         out_channel;
  logic signed [15:0] out_value;
  logic               moving;
  logic               last;
  modport source(output valid, out_channel, out_value, moving, last, input ready);
  modport sink(input valid, out_channel, out_value, moving, last, output ready);
endinterface
`default_nettype wire

>>> design/eased_pose_transition.sv
// Top level of the eased pose transition block: front queue and back sequencer.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    op, channel, value, now, duration, easing
//   out_o    out  valid/ready    out_channel, out_value, moving, last
//
// The sequencer takes a load while idle and walks all NCH channels for a snap. A tick or
// transition while moving runs entry, the ten-step divider, S_EASE (with S_D1 and S_D2
// for a curved mode), S_LMUL, S_LADD, S_D1 and S_D2 per linear channel (only S_LMUL once
// the eased time reaches 1000) and closure; an ended move copies the target instead. A
// transition then compares all NCH channels, decides, and copies or snaps unless the move
// already heads to the staged pose; a tick emits NCH transfers, one a cycle unless stalled.
// Reset is asynchronous and clears all poses and timing state at once.
// An output stall holds the sequencer; the two-entry queue then fills and drops in_i.ready.
`default_nettype none
module eased_pose_transition import ept_pkg::*; #(
  parameter int NUM_LINEAR_CHANNELS = 12
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ept_in_if.sink    in_i,
  ept_out_if.source out_o
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  ept_front #(.NUM_LINEAR_CHANNELS(NUM_LINEAR_CHANNELS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  ept_back #(.NUM_LINEAR_CHANNELS(NUM_LINEAR_CHANNELS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

>>> design/ept_front.sv
// Front end: accepts input items, classifies them and queues them for execution.
`default_nettype none
module ept_front import ept_pkg::*; #(
  parameter int NUM_LINEAR_CHANNELS = 12
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ept_in_if.sink    in_i,
  output logic      cmd_valid_o,
  output cmd_t      cmd_o,
  input  wire logic cmd_ready_i
);

  cmd_t       fifo_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  cmd_t       cls;
  logic       push, pop;

  always_comb begin
    cls.op       = op_e'(in_i.op);
    cls.channel  = in_i.channel;
    cls.now      = in_i.now;
    cls.duration = in_i.duration;
    cls.easing   = in_i.easing;
    cls.load_en  = (in_i.op == OP_LOAD) &&
                   ({1'b0, in_i.channel} <= 5'(NUM_LINEAR_CHANNELS));
    // The closure channel stores only its style bit.
    if ({1'b0, in_i.channel} == 5'(NUM_LINEAR_CHANNELS)) begin
      cls.value = {15'd0, in_i.value[0]};
    end else begin
      cls.value = in_i.value;
    end
  end

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rptr_q];
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

>>> design/ept_back.sv
// Back end: sequencer that stages loads, advances, snaps, starts and emits the pose.
`default_nettype none
module ept_back import ept_pkg::*; #(
  parameter int NUM_LINEAR_CHANNELS = 12
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_ready_o,
  ept_out_if.source out_o
);

  localparam int NCH = NUM_LINEAR_CHANNELS + 1;
  localparam int IW  = $clog2(NCH);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_LINEAR_CHANNELS);
  localparam logic [IW-1:0] LAST_LIN = IW'(NUM_LINEAR_CHANNELS - 1);

  st_e                st_q, st_d;
  logic [IW-1:0]      idx_q, idx_d;
  cmd_t               cmd_q, cmd_d;
  logic [31:0]        start_q, start_d;
  logic [15:0]        span_q, span_d;
  logic [1:0]         curve_q, curve_d;
  logic               active_q, active_d;
  logic signed [15:0] stg_q [NCH], stg_d [NCH];
  logic signed [15:0] org_q [NCH], org_d [NCH];
  logic signed [15:0] tgt_q [NCH], tgt_d [NCH];
  logic signed [15:0] cur_q [NCH], cur_d [NCH];
  logic [25:0]        rem_q, rem_d;
  logic [9:0]         quo_q, quo_d;
  logic [3:0]         bit_q, bit_d;
  logic [10:0]        t_q, t_d;
  logic [26:0]        dx_q, dx_d;
  logic [54:0]        dprod_q, dprod_d;
  logic               neg_q, neg_d;
  logic               inv_q, inv_d;
  logic               in_lerp_q, in_lerp_d;
  logic signed [28:0] prod_q, prod_d;
  logic               eq_tgt_q, eq_tgt_d, eq_cur_q, eq_cur_d;
  logic               ov_q, ov_d;
  logic [3:0]         och_q, och_d;
  logic signed [15:0] oval_q, oval_d;
  logic               omov_q, omov_d, olast_q, olast_d;

  logic [31:0]        elapsed;
  logic [25:0]        cand;
  logic [10:0]        p, inv;
  logic [20:0]        sq;
  logic [17:0]        q0, q;
  logic [27:0]        r;
  logic signed [18:0] qs, sum;
  logic signed [16:0] dd;
  logic signed [29:0] sadj;
  logic [IW-1:0]      ld_idx;

  assign out_o.valid       = ov_q;
  assign out_o.out_channel = och_q;
  assign out_o.out_value   = oval_q;
  assign out_o.moving      = omov_q;
  assign out_o.last        = olast_q;

  always_comb begin
    st_d = st_q;  idx_d = idx_q;  cmd_d = cmd_q;
    start_d = start_q;  span_d = span_q;  curve_d = curve_q;  active_d = active_q;
    stg_d = stg_q;  org_d = org_q;  tgt_d = tgt_q;  cur_d = cur_q;
    rem_d = rem_q;  quo_d = quo_q;  bit_d = bit_q;  t_d = t_q;
    dx_d = dx_q;  dprod_d = dprod_q;  neg_d = neg_q;  inv_d = inv_q;
    in_lerp_d = in_lerp_q;  prod_d = prod_q;
    eq_tgt_d = eq_tgt_q;  eq_cur_d = eq_cur_q;
    ov_d = ov_q && !out_o.ready;
    och_d = och_q;  oval_d = oval_q;  omov_d = omov_q;  olast_d = olast_q;
    cmd_ready_o = 1'b0;

    elapsed = cmd_q.now - start_q;
    cand    = 26'(span_q) << bit_q;
    p       = {1'b0, quo_q};
    inv     = T_FULL - p;
    sq      = 21'd0;
    q0      = dprod_q[54:RECIP_SHIFT];
    r       = 28'(dx_q) - 28'(q0) * 28'd1000;
    q       = (r >= 28'd1000) ? q0 + 18'd1 : q0;
    qs      = neg_q ? -$signed({1'b0, q}) : $signed({1'b0, q});
    sum     = 19'(org_q[idx_q]) + qs;
    dd      = 17'(tgt_q[idx_q]) - 17'(org_q[idx_q]);
    sadj    = (prod_q < 0) ? 30'(prod_q) - 30'sd500 : 30'(prod_q) + 30'sd500;
    ld_idx  = IW'(cmd_i.channel);

    case (st_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          idx_d = '0;
          case (cmd_i.op)
            OP_LOAD: begin
              if (cmd_i.load_en) stg_d[ld_idx] = cmd_i.value;
            end
            OP_SNAP: st_d = S_SNAP;
            default: st_d = S_ADV;
          endcase
        end
      end
      S_ADV: begin
        if (!active_q) begin
          st_d = (cmd_q.op == OP_TICK) ? S_EMIT : S_CMP;
          eq_tgt_d = 1'b1;
          eq_cur_d = 1'b1;
        end else if (elapsed >= {16'd0, span_q}) begin
          st_d = S_COPY_TGT;
        end else begin
          rem_d = 26'(elapsed[15:0]) * 26'd1000;
          quo_d = '0;
          bit_d = 4'd9;
          st_d  = S_DIV;
        end
      end
      S_DIV: begin
        // Quotient is below 1000, so ten restoring steps cover it.
        if (rem_q >= cand) begin
          rem_d = rem_q - cand;
          quo_d[bit_q] = 1'b1;
        end
        if (bit_q == 4'd0) st_d = S_EASE;
        else bit_d = bit_q - 4'd1;
      end
      S_EASE: begin
        in_lerp_d = 1'b0;
        neg_d     = 1'b0;
        if (p >= T_FULL) begin
          t_d = T_FULL;
          st_d = S_LMUL;
        end else if (curve_q == CURVE_DECEL) begin
          sq    = 21'(inv) * 21'(inv);
          inv_d = 1'b1;
          dx_d  = 27'(sq);
          st_d  = S_D1;
        end else if (curve_q == CURVE_SMOOTH) begin
          if (p < T_HALF) begin
            sq    = (21'(p) * 21'(p)) << 1;
            inv_d = 1'b0;
          end else begin
            sq    = (21'(inv) * 21'(inv)) << 1;
            inv_d = 1'b1;
          end
          dx_d = 27'(sq);
          st_d = S_D1;
        end else begin
          t_d  = p;
          st_d = S_LMUL;
        end
      end
      S_D1: begin
        dprod_d = 55'(dx_q) * 55'(RECIP_M);
        st_d    = S_D2;
      end
      S_D2: begin
        if (!in_lerp_q) begin
          t_d  = inv_q ? T_FULL - 11'(q) : 11'(q);
          st_d = S_LMUL;
        end else begin
          cur_d[idx_q] = sum[15:0];
          if (idx_q == LAST_LIN) st_d = S_CLOS;
          else begin
            idx_d = idx_q + 1'b1;
            st_d  = S_LMUL;
          end
        end
      end
      S_LMUL: begin
        if (t_q >= T_FULL) begin
          cur_d[idx_q] = tgt_q[idx_q];
          if (idx_q == LAST_LIN) st_d = S_CLOS;
          else idx_d = idx_q + 1'b1;
        end else begin
          prod_d = 29'(dd) * 29'($signed({1'b0, t_q}));
          st_d   = S_LADD;
        end
      end
      S_LADD: begin
        neg_d     = sadj < 0;
        dx_d      = (sadj < 0) ? 27'(-sadj) : 27'(sadj);
        in_lerp_d = 1'b1;
        st_d      = S_D1;
      end
      S_CLOS: begin
        if (org_q[LAST_IDX] == tgt_q[LAST_IDX]) begin
          cur_d[LAST_IDX] = tgt_q[LAST_IDX];
        end else if (tgt_q[LAST_IDX] == CLOSURE_CURVED) begin
          cur_d[LAST_IDX] = (t_q < T_CURVED) ? org_q[LAST_IDX] : tgt_q[LAST_IDX];
        end else begin
          cur_d[LAST_IDX] = (t_q < T_FILLED) ? org_q[LAST_IDX] : tgt_q[LAST_IDX];
        end
        idx_d    = '0;
        eq_tgt_d = 1'b1;
        eq_cur_d = 1'b1;
        st_d     = (cmd_q.op == OP_TICK) ? S_EMIT : S_CMP;
      end
      S_COPY_TGT: begin
        cur_d[idx_q] = tgt_q[idx_q];
        if (idx_q == LAST_IDX) begin
          active_d = 1'b0;
          idx_d    = '0;
          eq_tgt_d = 1'b1;
          eq_cur_d = 1'b1;
          st_d     = (cmd_q.op == OP_TICK) ? S_EMIT : S_CMP;
        end else idx_d = idx_q + 1'b1;
      end
      S_CMP: begin
        eq_tgt_d = eq_tgt_q && (tgt_q[idx_q] == stg_q[idx_q]);
        eq_cur_d = eq_cur_q && (cur_q[idx_q] == stg_q[idx_q]);
        if (idx_q == LAST_IDX) st_d = S_DECIDE;
        else idx_d = idx_q + 1'b1;
      end
      S_DECIDE: begin
        idx_d = '0;
        if (active_q && eq_tgt_q) begin
          st_d = S_IDLE;
        end else if (eq_cur_q || (cmd_q.duration == 16'd0)) begin
          st_d = S_SNAP;
        end else begin
          start_d  = cmd_q.now;
          span_d   = cmd_q.duration;
          curve_d  = cmd_q.easing;
          active_d = 1'b1;
          st_d     = S_COPY_ST;
        end
      end
      S_SNAP: begin
        cur_d[idx_q] = stg_q[idx_q];
        org_d[idx_q] = stg_q[idx_q];
        tgt_d[idx_q] = stg_q[idx_q];
        if (idx_q == LAST_IDX) begin
          start_d  = cmd_q.now;
          span_d   = 16'd0;
          active_d = 1'b0;
          st_d     = S_IDLE;
        end else idx_d = idx_q + 1'b1;
      end
      S_COPY_ST: begin
        org_d[idx_q] = cur_q[idx_q];
        tgt_d[idx_q] = stg_q[idx_q];
        if (idx_q == LAST_IDX) st_d = S_IDLE;
        else idx_d = idx_q + 1'b1;
      end
      S_EMIT: begin
        // A new channel enters the output register once the old one has left.
        if (!ov_q || out_o.ready) begin
          ov_d    = 1'b1;
          och_d   = 4'(idx_q);
          oval_d  = cur_q[idx_q];
          omov_d  = active_q;
          olast_d = (idx_q == LAST_IDX);
          if (idx_q == LAST_IDX) st_d = S_IDLE;
          else idx_d = idx_q + 1'b1;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    bit_q   <= bit_d;
    t_q     <= t_d;
    dx_q    <= dx_d;
    dprod_q <= dprod_d;
    neg_q   <= neg_d;
    inv_q   <= inv_d;
    in_lerp_q <= in_lerp_d;
    prod_q  <= prod_d;
    eq_tgt_q <= eq_tgt_d;
    eq_cur_q <= eq_cur_d;
    och_q   <= och_d;
    oval_q  <= oval_d;
    omov_q  <= omov_d;
    olast_q <= olast_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      idx_q    <= '0;
      start_q  <= '0;
      span_q   <= '0;
      curve_q  <= '0;
      active_q <= 1'b0;
      ov_q     <= 1'b0;
      for (int i = 0; i < NCH; i++) begin
        stg_q[i] <= '0;
        org_q[i] <= '0;
        tgt_q[i] <= '0;
        cur_q[i] <= '0;
      end
    end else begin
      st_q     <= st_d;
      idx_q    <= idx_d;
      start_q  <= start_d;
      span_q   <= span_d;
      curve_q  <= curve_d;
      active_q <= active_d;
      ov_q     <= ov_d;
      stg_q    <= stg_d;
      org_q    <= org_d;
      tgt_q    <= tgt_d;
      cur_q    <= cur_d;
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_eased_pose_transition.sv
// Self-checking testbench for the eased pose transition block.
module tb_eased_pose_transition;
  import ept_pkg::*;

  localparam int NLIN      = 12;
  localparam int NPOSE     = NLIN + 1;
  localparam int RAND_ITEMS = 280;
  localparam int LIMIT     = 600000;
  localparam int DRAIN     = 150;

  typedef struct {
    op_e                op;
    logic [3:0]         ch;
    logic signed [15:0] val;
    logic [31:0]        now;
    logic [15:0]        dur;
    logic [1:0]         eas;
    bit                 known;
    logic signed [15:0] kval;
  } pose_cmd_t;

  typedef struct {
    logic [3:0]         ch;
    logic signed [15:0] val;
    logic               moving;
    logic               last;
  } pose_beat_t;

  logic clk;
  logic rst_n;
  ept_in_if  in_bus();
  ept_out_if out_bus();

  eased_pose_transition #(.NUM_LINEAR_CHANNELS(NLIN)) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus.sink),
    .out_o (out_bus.source)
  );

  // Predictor state.
  logic signed [15:0] staged_q [NPOSE];
  logic signed [15:0] origin_q [NPOSE];
  logic signed [15:0] target_q [NPOSE];
  logic signed [15:0] current_q[NPOSE];
  logic [31:0]        start_q;
  logic [15:0]        span_q;
  logic [1:0]         curve_q;
  bit                 active_q;

  pose_cmd_t  cmds_in_flight[$];
  pose_beat_t pose_beats_due[$];
  int         mismatches;
  int         cycles;
  int         send_idle_pct;
  int         stall_pct;
  logic [31:0] ms_now;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned shape_progress(logic [1:0] mode, int unsigned p);
    int unsigned inv;
    if (p >= 1000) return 1000;
    inv = 1000 - p;
    if (mode == CURVE_DECEL) return 1000 - (inv * inv) / 1000;
    if (mode == CURVE_SMOOTH) begin
      if (p < 500) return (2 * p * p) / 1000;
      return 1000 - (2 * inv * inv) / 1000;
    end
    return p;
  endfunction

  function automatic logic signed [15:0] blend_channel(logic signed [15:0] a,
                                                       logic signed [15:0] b,
                                                       int unsigned t);
    int d;
    int q;
    if (t >= 1000) return b;
    d = int'(b) - int'(a);
    q = (d * int'(t) + (d >= 0 ? 500 : -500)) / 1000;
    return 16'(int'(a) + q);
  endfunction

  function automatic logic signed [15:0] closure_at(logic signed [15:0] a,
                                                    logic signed [15:0] b,
                                                    int unsigned t);
    if (a == b) return b;
    if (b == CLOSURE_CURVED) return (t < 850) ? a : b;
    return (t < 150) ? a : b;
  endfunction

  task automatic advance_pose(logic [31:0] now);
    logic [31:0] elapsed;
    longint unsigned raw;
    int unsigned t;
    if (!active_q) return;
    elapsed = now - start_q;
    if (elapsed >= {16'd0, span_q}) begin
      current_q = target_q;
      active_q  = 1'b0;
      return;
    end
    raw = (longint'(elapsed) * 1000) / longint'(span_q);
    t = shape_progress(curve_q, int'(raw));
    for (int i = 0; i < NLIN; i++) current_q[i] = blend_channel(origin_q[i], target_q[i], t);
    current_q[NLIN] = closure_at(origin_q[NLIN], target_q[NLIN], t);
  endtask

  task automatic snap_pose(logic [31:0] now);
    current_q = staged_q;
    origin_q  = staged_q;
    target_q  = staged_q;
    start_q   = now;
    span_q    = '0;
    active_q  = 1'b0;
  endtask

  task automatic predict_pose(pose_cmd_t c);
    pose_beat_t b;
    case (c.op)
      OP_LOAD: begin
        if (c.ch < NLIN) staged_q[c.ch] = c.val;
        else if (c.ch == NLIN) staged_q[c.ch] = {15'd0, c.val[0]};
      end
      OP_TRANS: begin
        advance_pose(c.now);
        if (!(active_q && target_q == staged_q)) begin
          if (current_q == staged_q || c.dur == 0) begin
            snap_pose(c.now);
          end else begin
            origin_q = current_q;
            target_q = staged_q;
            start_q  = c.now;
            span_q   = c.dur;
            curve_q  = c.eas;
            active_q = 1'b1;
          end
        end
      end
      OP_SNAP: snap_pose(c.now);
      default: begin
        advance_pose(c.now);
        for (int i = 0; i < NPOSE; i++) begin
          b.ch     = 4'(i);
          b.val    = c.known ? (i == NLIN ? 16'sd0 : c.kval) : current_q[i];
          b.moving = c.known ? 1'b0 : active_q;
          b.last   = (i == NLIN);
          pose_beats_due.push_back(b);
        end
      end
    endcase
  endtask

  // Result checking and input acceptance tracking.
  always @(posedge clk) begin
    pose_beat_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pose_beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: ch %0d value %0d", out_bus.out_channel,
                   out_bus.out_value);
      end else begin
        want = pose_beats_due.pop_front();
        if (out_bus.out_channel !== want.ch || out_bus.out_value !== want.val ||
            out_bus.moving !== want.moving || out_bus.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected ch %0d val %0d mov %0b last %0b, got ch %0d val %0d mov %0b last %0b",
                     want.ch, want.val, want.moving, want.last, out_bus.out_channel,
                     out_bus.out_value, out_bus.moving, out_bus.last);
        end
      end
    end
    if (rst_n && in_bus.valid && in_bus.ready && cmds_in_flight.size() > 0)
      predict_pose(cmds_in_flight.pop_front());
  end

  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= stall_pct);
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("eased_pose_transition verification failed");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic push_cmd(pose_cmd_t c);
    if ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cmds_in_flight.push_back(c);
    in_bus.valid    <= 1'b1;
    in_bus.op       <= c.op;
    in_bus.channel  <= c.ch;
    in_bus.value    <= c.val;
    in_bus.now      <= c.now;
    in_bus.duration <= c.dur;
    in_bus.easing   <= c.eas;
    do @(negedge clk); while (!in_bus.ready);
    @(posedge clk);
  endtask

  task automatic wait_quiet();
    in_bus.valid <= 1'b0;
    while (pose_beats_due.size() != 0 || cmds_in_flight.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 4))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pose_cmd_t make_cmd(op_e op, int ch, logic signed [15:0] val,
                                         logic [31:0] now, logic [15:0] dur,
                                         logic [1:0] eas);
    pose_cmd_t c;
    c.op = op; c.ch = 4'(ch); c.val = val; c.now = now;
    c.dur = dur; c.eas = eas; c.known = 1'b0; c.kval = '0;
    return c;
  endfunction

  // One well-formed move: a few loads, a transition and a run of ticks.
  task automatic tween_sequence();
    logic [15:0] dur;
    int ticks;
    repeat ($urandom_range(1, 4))
      push_cmd(make_cmd(OP_LOAD, $urandom_range(0, NLIN), pick_value(), $urandom,
                        16'($urandom), 2'($urandom)));
    case ($urandom_range(0, 9))
      0: dur = 16'd0;
      1: dur = 16'hFFFF;
      default: dur = 16'($urandom_range(1, 2000));
    endcase
    ms_now += $urandom_range(0, 50);
    push_cmd(make_cmd(OP_TRANS, $urandom_range(0, 15), 16'($urandom), ms_now, dur,
                      2'($urandom)));
    ticks = $urandom_range(1, 4);
    repeat (ticks) begin
      ms_now += $urandom_range(0, int'(dur) / 3 + 20);
      push_cmd(make_cmd(OP_TICK, $urandom_range(0, 15), 16'($urandom), ms_now,
                        16'($urandom), 2'($urandom)));
    end
  endtask

  task automatic noise_item();
    logic [31:0] t;
    t = ($urandom_range(0, 3) == 0) ? $urandom : ms_now + $urandom_range(0, 300);
    push_cmd(make_cmd(op_e'($urandom_range(0, 3)), $urandom_range(0, 15), 16'($urandom), t,
                      16'($urandom), 2'($urandom)));
  endtask

  pose_cmd_t directed[] = '{
    '{OP_TICK,  4'd0,  16'sd0,      32'd0,          16'd0,     2'd0, 1'b1, 16'sd0},
    '{OP_LOAD,  4'd0,  16'sh7FFF,   32'd0,          16'd0,     2'd0, 1'b0, 16'sd0},
    '{OP_LOAD,  4'd1,  16'sh8000,   32'd0,          16'd0,     2'd0, 1'b0, 16'sd0},
    '{OP_LOAD,  4'd12, 16'shFFFF,   32'd0,          16'd0,     2'd0, 1'b0, 16'sd0},
    '{OP_LOAD,  4'd13, 16'sd5,      32'd0,          16'd0,     2'd0, 1'b0, 16'sd0},
    '{OP_LOAD,  4'd15, 16'sd9,      32'd0,          16'd0,     2'd0, 1'b0, 16'sd0},
    '{OP_TRANS, 4'd0,  16'sd0,      32'd100,        16'd0,     2'd0, 1'b0, 16'sd0},
    '{OP_TICK,  4'd0,  16'sd0,      32'd150,        16'd0,     2'd0, 1'b0, 16'sd0},
    '{OP_LOAD,  4'd0,  16'sh8000,   32'd0,          16'd0,     2'd0, 1'b0, 16'sd0},
    '{OP_TRANS, 4'd0,  16'sd0,      32'd200,        16'd1000,  2'd0, 1'b0, 16'sd0},
    '{OP_TICK,  4'd0,  16'sd0,      32'd700,        16'd0,     2'd0, 1'b0, 16'sd0},
    '{OP_TRANS, 4'd0,  16'sd0,      32'd800,        16'd40,    2'd1, 1'b0, 16'sd0},
    '{OP_TICK,  4'd0,  16'sd0,      32'd1200,       16'd0,     2'd0, 1'b0, 16'sd0},
    '{OP_LOAD,  4'd1,  16'sd0,      32'd0,          16'd0,     2'd0, 1'b0, 16'sd0},
    '{OP_TRANS, 4'd0,  16'sd0,      32'd1300,       16'hFFFF,  2'd1, 1'b0, 16'sd0},
    '{OP_TICK,  4'd0,  16'sd0,      32'd31300,      16'd0,     2'd0, 1'b0, 16'sd0},
    '{OP_LOAD,  4'd12, 16'sd0,      32'd0,          16'd0,     2'd0, 1'b0, 16'sd0},
    '{OP_TRANS, 4'd0,  16'sd0,      32'd40000,      16'd500,   2'd2, 1'b0, 16'sd0},
    '{OP_TICK,  4'd0,  16'sd0,      32'd40100,      16'd0,     2'd0, 1'b0, 16'sd0},
    '{OP_TICK,  4'd0,  16'sd0,      32'd40400,      16'd0,     2'd0, 1'b0, 16'sd0},
    '{OP_LOAD,  4'd5,  16'sd123,    32'd0,          16'd0,     2'd0, 1'b0, 16'sd0},
    '{OP_TRANS, 4'd0,  16'sd0,      32'hFFFF_FF00,  16'd1000,  2'd3, 1'b0, 16'sd0},
    '{OP_TICK,  4'd0,  16'sd0,      32'h0000_0100,  16'd0,     2'd0, 1'b0, 16'sd0},
    '{OP_SNAP,  4'd0,  16'sd0,      32'd5,          16'd0,     2'd0, 1'b0, 16'sd0},
    '{OP_TICK,  4'd0,  16'sd0,      32'd5,          16'd0,     2'd0, 1'b0, 16'sd0}
  };

  initial begin
    int sent;
    mismatches = 0;
    cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    ms_now = 32'd100000;
    for (int i = 0; i < NPOSE; i++) begin
      staged_q[i] = '0; origin_q[i] = '0; target_q[i] = '0; current_q[i] = '0;
    end
    start_q = '0; span_q = '0; curve_q = '0; active_q = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.op = OP_LOAD;
    in_bus.channel = '0;
    in_bus.value = '0;
    in_bus.now = '0;
    in_bus.duration = '0;
    in_bus.easing = '0;
    out_bus.ready = 1'b0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) push_cmd(directed[i]);
    wait_quiet();

    // Idling phases: none, sender only, receiver only, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 6 : 47) : 0;
      stall_pct     = (ph == 2 || ph == 3) ? (ph == 3 ? 6 : 47) : 0;
      sent = 0;
      while (sent < RAND_ITEMS / 4) begin
        if ($urandom_range(0, 9) < 7) begin
          tween_sequence();
          sent += 6;
        end else begin
          noise_item();
          sent++;
        end
      end
      wait_quiet();
    end

    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && pose_beats_due.size() == 0)
      $display("eased_pose_transition verification clean");
    else
      $display("eased_pose_transition verification failed");
    $finish;
  end

endmodule

>>> files.f
design/ept_pkg.sv
design/ept_if.sv
design/ept_front.sv
design/ept_back.sv
design/eased_pose_transition.sv
tb/tb_eased_pose_transition.sv
